// ===== rtl/lwm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwm_pkg: shared types and constants of the levels window mapper
// Register indexes, fixed field widths and the status bundle of the
// midtone level calculator.
// ----------------------------------------------------------------------------
package lwm_pkg;

    localparam int CFG_IDX_BITS = 2;
    localparam int MID_BITS     = 16;
    localparam int LEVEL_BITS   = 8;
    // Numerator and shifted divisor width of the midtone level division.
    localparam int MNUM_BITS    = 26;
    localparam int MCNT_BITS    = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BLACK = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WHITE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MID   = 2'd2;

    localparam logic [MID_BITS-1:0]   MID_ONE         = 16'd4096;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX       = 8'd255;
    // Midtone level that belongs to the reset mid ratio of 1.0.
    localparam logic [LEVEL_BITS-1:0] MID_RESET_LEVEL = 8'd128;

    typedef struct packed {
        logic                  busy;
        logic [LEVEL_BITS-1:0] level;
    } t_mid_status;

endpackage : lwm_pkg
`default_nettype wire

// ===== rtl/lwm_mid_calc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwm_mid_calc: midtone level calculator
// Works out m = round(255*M/(4096+M)) with a restoring divider that
// produces one quotient bit per cycle after each write of the mid ratio.
// ----------------------------------------------------------------------------
module lwm_mid_calc (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [lwm_pkg::MID_BITS-1:0] i_mid,
    output lwm_pkg::t_mid_status              o_status
);
    import lwm_pkg::*;

    logic                  r_busy;
    logic [MCNT_BITS-1:0]  r_cnt;
    logic [MNUM_BITS-1:0]  r_rem;
    logic [MNUM_BITS-1:0]  r_dsr;
    logic [LEVEL_BITS-1:0] r_q;
    logic [LEVEL_BITS-1:0] r_level;

    logic [MNUM_BITS-1:0]  n_num;
    logic [MNUM_BITS-1:0]  n_dsr;
    logic                  w_ge;

    // Rounding is folded in: (510*M + den) / (2*den), with den = 4096 + M.
    assign n_num = (MNUM_BITS'(i_mid) << 9) - MNUM_BITS'(i_mid) + MNUM_BITS'(MID_ONE);
    // The divisor 2*den starts shifted up by seven for the top quotient bit.
    assign n_dsr = (MNUM_BITS'(i_mid) << 8) + (MNUM_BITS'(MID_ONE) << 8);
    assign w_ge  = r_rem >= r_dsr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_level <= MID_RESET_LEVEL;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '1;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy  <= 1'b0;
                r_level <= {r_q[LEVEL_BITS-2:0], w_ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= n_num;
            r_dsr <= n_dsr;
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsr;
            end
            r_dsr <= r_dsr >> 1;
            r_q   <= {r_q[LEVEL_BITS-2:0], w_ge};
        end
    end

    assign o_status.busy  = r_busy;
    assign o_status.level = r_level;

    a_start_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("mid calculator did not start");

    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_rem} < {r_dsr, 1'b0}))
        else $error("mid calculator remainder out of range");

    a_last_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0 && !i_start) |=> !r_busy)
        else $error("mid calculator ran past its last step");

endmodule : lwm_mid_calc
`default_nettype wire

// ===== rtl/levels_window_map_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// levels_window_map_core: black / mid / white levels mapping
// Maps one signed sample to an 8-bit grey level through a threshold, scale
// and pipelined restoring division datapath.
// ----------------------------------------------------------------------------
// Throughput: one sample per clock while neither i_stall nor a midtone
// calculation holds the flow, set by the ten-stage datapath in which the
// division by the window span takes one quotient bit per stage.
// A write of mid_ratio holds o_stall high and o_cfg_ready low while the
// midtone divider runs. Synchronous active-low reset empties the
// pipeline and restores black 0, white 0 and mid ratio 1.0.
module levels_window_map_core #(
    parameter  int SAMPLE_BITS = 16,
    localparam int CfgBits     = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output      logic                             o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]    i_sample,
    output      logic                             o_valid,
    input  wire logic                             i_stall,
    output      logic [lwm_pkg::LEVEL_BITS-1:0]   o_grey_level,
    input  wire logic                             i_cfg_valid,
    output      logic                             o_cfg_ready,
    input  wire logic [lwm_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CfgBits-1:0]               i_cfg_data
);
    import lwm_pkg::*;

    localparam int W      = SAMPLE_BITS;
    localparam int PW     = W + 10;        // product width
    localparam int KW     = LEVEL_BITS + 1;
    localparam int DIV_REG = LEVEL_BITS - 1; // division stages with registers
    localparam int NS     = DIV_REG + 3;   // A, B, division stages, output

    // Configuration.
    logic signed [W-1:0]   r_black;
    logic signed [W-1:0]   r_white;
    logic [MID_BITS-1:0]   r_mid;
    t_mid_status           w_mid;
    logic                  w_cfg_we;
    logic                  w_mid_start;

    // Handshake.
    logic [NS-1:0]         r_v;
    logic [NS-1:0]         w_en;
    logic                  w_in_accept;

    // Stage A.
    logic signed [W:0]     w_dxb;
    logic signed [W:0]     w_span;
    logic signed [W+1:0]   w_sum2;
    logic [W:0]            n_a_n;
    logic [KW-1:0]         n_a_k;
    logic [LEVEL_BITS-1:0] n_a_off;
    logic [W:0]            r_a_n;
    logic [KW-1:0]         r_a_k;
    logic [LEVEL_BITS-1:0] r_a_off;
    logic [W:0]            r_a_span;
    logic                  r_a_zero;
    logic                  r_a_full;

    // Stage B.
    logic [PW-1:0]         r_b_prod;
    logic [W:0]            r_b_span;
    logic [LEVEL_BITS-1:0] r_b_off;
    logic                  r_b_zero;
    logic                  r_b_full;

    // Division stages.
    logic [PW-1:0]         r_d_rem  [DIV_REG];
    logic [LEVEL_BITS-1:0] r_d_q    [DIV_REG];
    logic [W:0]            r_d_span [DIV_REG];
    logic [LEVEL_BITS-1:0] r_d_off  [DIV_REG];
    logic                  r_d_zero [DIV_REG];
    logic                  r_d_full [DIV_REG];

    // Output stage.
    logic                  w_ge0;
    logic [LEVEL_BITS-1:0] w_q;
    logic [LEVEL_BITS:0]   w_sum;
    logic [LEVEL_BITS-1:0] n_level;
    logic [LEVEL_BITS-1:0] r_level;

    // ------------------------------------------------------------------
    // Configuration registers and midtone level.
    // ------------------------------------------------------------------
    assign o_cfg_ready = !w_mid.busy;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_mid_start = w_cfg_we && (i_cfg_index == CFG_MID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black <= '0;
            r_white <= '0;
            r_mid   <= MID_ONE;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                CFG_BLACK: r_black <= i_cfg_data[W-1:0];
                CFG_WHITE: r_white <= i_cfg_data[W-1:0];
                CFG_MID:   r_mid   <= i_cfg_data[MID_BITS-1:0];
                default:   ;
            endcase
        end
    end

    lwm_mid_calc u_mid_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mid_start),
        .i_mid    (i_cfg_data[MID_BITS-1:0]),
        .o_status (w_mid)
    );

    // ------------------------------------------------------------------
    // Pipeline flow: a stage moves on when it is empty or the next moves.
    // ------------------------------------------------------------------
    assign w_en[NS-1] = !r_v[NS-1] || !i_stall;
    for (genvar s = 0; s < NS - 1; s++) begin : g_en
        assign w_en[s] = !r_v[s] || w_en[s+1];
    end

    assign o_stall     = !w_en[0] || w_mid.busy;
    assign w_in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= w_in_accept;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: window tests and choice of numerator, scale and offset.
    // ------------------------------------------------------------------
    assign w_dxb  = {i_sample[W-1], i_sample} - {r_black[W-1], r_black};
    assign w_span = {r_white[W-1], r_white} - {r_black[W-1], r_black};
    assign w_sum2 = {i_sample[W-1], i_sample, 1'b0}
                  - {{2{r_black[W-1]}}, r_black}
                  - {{2{r_white[W-1]}}, r_white};

    always_comb begin
        if (r_mid == MID_ONE) begin
            n_a_n   = w_dxb;
            n_a_k   = KW'(LEVEL_MAX);
            n_a_off = '0;
        end else if (w_sum2[W+1]) begin
            // Lower half of the window ramps from 0 towards m.
            n_a_n   = w_dxb;
            n_a_k   = {w_mid.level, 1'b0};
            n_a_off = '0;
        end else begin
            n_a_n   = w_sum2[W:0];
            n_a_k   = {1'b0, LEVEL_MAX - w_mid.level};
            n_a_off = w_mid.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a_n    <= n_a_n;
            r_a_k    <= n_a_k;
            r_a_off  <= n_a_off;
            r_a_span <= w_span;
            r_a_zero <= i_sample <= r_black;
            r_a_full <= i_sample >= r_white;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: scale.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_b_prod <= PW'(r_a_n) * PW'(r_a_k);
            r_b_span <= r_a_span;
            r_b_off  <= r_a_off;
            r_b_zero <= r_a_zero;
            r_b_full <= r_a_full && !r_a_zero;
        end
    end

    // ------------------------------------------------------------------
    // Division by the span, one quotient bit per stage, top bit first.
    // ------------------------------------------------------------------
    for (genvar j = 0; j < DIV_REG; j++) begin : g_div
        localparam int SH = LEVEL_BITS - 1 - j;
        logic [PW-1:0]         w_rem_in;
        logic [W:0]            w_span_in;
        logic [LEVEL_BITS-1:0] w_q_in;
        logic [LEVEL_BITS-1:0] w_off_in;
        logic                  w_zero_in;
        logic                  w_full_in;
        logic [PW-1:0]         w_sub;
        logic                  w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in  = r_b_prod;
            assign w_span_in = r_b_span;
            assign w_q_in    = '0;
            assign w_off_in  = r_b_off;
            assign w_zero_in = r_b_zero;
            assign w_full_in = r_b_full;
        end else begin : g_next
            assign w_rem_in  = r_d_rem[j-1];
            assign w_span_in = r_d_span[j-1];
            assign w_q_in    = r_d_q[j-1];
            assign w_off_in  = r_d_off[j-1];
            assign w_zero_in = r_d_zero[j-1];
            assign w_full_in = r_d_full[j-1];
        end

        assign w_sub = PW'(w_span_in) << SH;
        assign w_ge  = w_rem_in >= w_sub;

        always_ff @(posedge i_clk) begin
            if (w_en[j+2]) begin
                r_d_rem[j]  <= w_ge ? (w_rem_in - w_sub) : w_rem_in;
                r_d_q[j]    <= {w_q_in[LEVEL_BITS-2:0], w_ge};
                r_d_span[j] <= w_span_in;
                r_d_off[j]  <= w_off_in;
                r_d_zero[j] <= w_zero_in;
                r_d_full[j] <= w_full_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: last quotient bit, offset, saturation and thresholds.
    // ------------------------------------------------------------------
    assign w_ge0 = r_d_rem[DIV_REG-1] >= PW'(r_d_span[DIV_REG-1]);
    assign w_q   = {r_d_q[DIV_REG-1][LEVEL_BITS-2:0], w_ge0};
    assign w_sum = {1'b0, w_q} + {1'b0, r_d_off[DIV_REG-1]};

    always_comb begin
        if (r_d_zero[DIV_REG-1]) begin
            n_level = '0;
        end else if (r_d_full[DIV_REG-1] || w_sum[LEVEL_BITS]) begin
            n_level = LEVEL_MAX;
        end else begin
            n_level = w_sum[LEVEL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_level <= n_level;
        end
    end

    assign o_valid      = r_v[NS-1];
    assign o_grey_level = r_level;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_mid_write_stalls : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_start |=> o_stall)
        else $error("input not stalled while the midtone level is worked out");

    a_stage_a_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && !w_en[0]) |=> r_v[0])
        else $error("first stage dropped a held transaction");

    a_quotient_fits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[1] && !r_b_zero && !r_b_full) |-> (r_b_prod < (PW'(r_b_span) << LEVEL_BITS)))
        else $error("scaled sample gives a quotient wider than a grey level");

endmodule : levels_window_map_core
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the levels window mapper
// A short table of directed samples and register writes, then twelve window
// settings with random samples under four idling patterns. Every accepted
// grey level is compared with a level typed into the table or with a local
// black / mid / white mapping model.
module testbench;
    import lwm_pkg::*;

    localparam int SMP_BITS        = 16;
    localparam int PIPE_DEPTH      = 10;
    localparam int QUIET_LIMIT     = 2000;
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int LONG_HOLD       = 64;
    localparam int MAX_REPORTS     = 20;
    // Index past the end of the register list; a write there is ignored.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_BITS-1:0] idx;
        logic [SMP_BITS-1:0]   data;
        bit                    fixed;
        logic [LEVEL_BITS-1:0] level;
    } t_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic signed [SMP_BITS-1:0]    i_sample;
    logic                          o_valid;
    logic                          i_stall;
    logic [LEVEL_BITS-1:0]         o_grey_level;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]       i_cfg_index;
    logic [SMP_BITS-1:0]           i_cfg_data;

    // Side lanes that travel with each sample: a level typed into the table.
    logic                          fixed_valid;
    logic [LEVEL_BITS-1:0]         fixed_level;

    // Local copy of the mapping registers.
    logic signed [SMP_BITS-1:0]    black_pt  = '0;
    logic signed [SMP_BITS-1:0]    white_pt  = '0;
    logic [MID_BITS-1:0]           mid_ratio = MID_ONE;

    logic [LEVEL_BITS-1:0]         pending_levels [$];
    int                            n_errors     = 0;
    int                            n_samples    = 0;
    int                            n_writes     = 0;
    int                            quiet_cycles = 0;
    int                            idle_pct     = 0;
    int                            stall_pct    = 0;
    int                            hold_requests = 0;

    levels_window_map_core #(
        .SAMPLE_BITS(SMP_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_grey_level(o_grey_level),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [LEVEL_BITS-1:0] map_sample(input logic signed [SMP_BITS-1:0] smp);
        longint x, b, t, span, top, unity, mm, den, mid_lvl, lvl;
        x     = smp;
        b     = black_pt;
        t     = white_pt;
        top   = LEVEL_MAX;
        unity = MID_ONE;
        if (x <= b) return '0;
        if (x >= t) return LEVEL_MAX;
        span = t - b;
        if (mid_ratio == MID_ONE) begin
            lvl = (x - b) * top / span;
        end else begin
            mm  = mid_ratio;
            den = unity + mm;
            // Midtone level, with halves rounded up.
            mid_lvl = (2 * top * mm + den) / (2 * den);
            if (2 * x < b + t) begin
                lvl = (x - b) * 2 * mid_lvl / span;
            end else begin
                lvl = (2 * x - b - t) * (top - mid_lvl) / span + mid_lvl;
            end
        end
        if (lvl < 0) lvl = 0;
        if (lvl > top) lvl = top;
        return lvl[LEVEL_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Transaction monitor: checks results, records predictions, tracks writes.
    always @(posedge i_clk) begin
        bit moved;
        logic [LEVEL_BITS-1:0] want;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                if (pending_levels.size() == 0) begin
                    report_mismatch($sformatf("grey level %0d with none expected",
                                              o_grey_level));
                end else begin
                    want = pending_levels.pop_front();
                    if (o_grey_level !== want)
                        report_mismatch($sformatf("grey level %0d, expected %0d",
                                                  o_grey_level, want));
                end
            end
            if (i_valid && !o_stall) begin
                moved = 1'b1;
                n_samples++;
                pending_levels.push_back(fixed_valid ? fixed_level : map_sample(i_sample));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                n_writes++;
                case (i_cfg_index)
                    CFG_BLACK: black_pt  = i_cfg_data;
                    CFG_WHITE: white_pt  = i_cfg_data;
                    CFG_MID:   mid_ratio = i_cfg_data;
                    default:   ;
                endcase
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stall, with a long hold-off when one is requested.
    initial begin : receiver
        int holds_served;
        holds_served = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                i_stall <= 1'b1;
                for (int n = 0; n < LONG_HOLD; n++) @(posedge i_clk);
            end else begin
                i_stall <= (int'($urandom_range(99)) < stall_pct);
            end
        end
    end

    task automatic wait_drained();
        i_valid     <= 1'b0;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_levels.size() != 0) @(posedge i_clk);
    endtask

    // Registers are only written once the pipeline has emptied.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [SMP_BITS-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic offer_sample(input logic [SMP_BITS-1:0] smp, input bit fixed,
                                input logic [LEVEL_BITS-1:0] level);
        i_cfg_valid <= 1'b0;
        while (int'($urandom_range(99)) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample    <= smp;
        fixed_valid <= fixed;
        fixed_level <= level;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic t_row reg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                     input logic [SMP_BITS-1:0] data);
        t_row r;
        r = '{1'b1, idx, data, 1'b0, '0};
        return r;
    endfunction

    function automatic t_row smp_row(input logic [SMP_BITS-1:0] smp);
        t_row r;
        r = '{1'b0, CFG_BLACK, smp, 1'b0, '0};
        return r;
    endfunction

    function automatic t_row pin_row(input logic [SMP_BITS-1:0] smp,
                                     input logic [LEVEL_BITS-1:0] level);
        t_row r;
        r = '{1'b0, CFG_BLACK, smp, 1'b1, level};
        return r;
    endfunction

    function automatic int pick_mid();
        case ($urandom_range(4))
            0:       return MID_ONE;
            1:       return 0;
            2:       return 65535;
            3:       return 4095 + int'($urandom_range(2));
            default: return int'($urandom_range(65535));
        endcase
    endfunction

    initial begin : stimulus
        t_row plan [$];
        int   b_sel, t_sel, m_sel, span, lo, hi, smp;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample    = '0;
        fixed_valid = 1'b0;
        fixed_level = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BLACK;
        i_cfg_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // After reset black and white are both 0: a collapsed window.
        plan.push_back(pin_row(16'sd0, '0));
        plan.push_back(pin_row(16'sd1, LEVEL_MAX));
        plan.push_back(pin_row(16'h8000, '0));
        plan.push_back(pin_row(16'h7FFF, LEVEL_MAX));
        plan.push_back(reg_row(CFG_SPARE, 16'hFFFF));
        plan.push_back(pin_row(16'sd1, LEVEL_MAX));
        // Widest window, linear ramp.
        plan.push_back(reg_row(CFG_BLACK, 16'h8000));
        plan.push_back(reg_row(CFG_WHITE, 16'h7FFF));
        plan.push_back(smp_row(16'h8001));
        plan.push_back(smp_row(16'h0000));
        plan.push_back(smp_row(16'h7FFE));
        // Mid ratio at both extremes.
        plan.push_back(reg_row(CFG_MID, 16'h0000));
        plan.push_back(smp_row(16'hFFFF));
        plan.push_back(smp_row(16'h4000));
        plan.push_back(reg_row(CFG_MID, 16'hFFFF));
        plan.push_back(smp_row(16'hC000));
        plan.push_back(smp_row(16'h7FFE));
        // Black not below white: only the two thresholds apply.
        plan.push_back(reg_row(CFG_BLACK, 16'd100));
        plan.push_back(reg_row(CFG_WHITE, 16'd100));
        plan.push_back(pin_row(16'd100, '0));
        plan.push_back(pin_row(16'd101, LEVEL_MAX));
        plan.push_back(reg_row(CFG_BLACK, 16'd200));
        plan.push_back(reg_row(CFG_WHITE, 16'hFF38));
        plan.push_back(pin_row(16'd0, '0));
        plan.push_back(pin_row(16'd201, LEVEL_MAX));
        // Narrow window, linear and just off the linear ratio.
        plan.push_back(reg_row(CFG_BLACK, 16'hFFFB));
        plan.push_back(reg_row(CFG_WHITE, 16'd5));
        plan.push_back(reg_row(CFG_MID, MID_ONE));
        plan.push_back(smp_row(16'hFFFC));
        plan.push_back(smp_row(16'h0000));
        plan.push_back(smp_row(16'd4));
        plan.push_back(reg_row(CFG_MID, 16'd4095));
        plan.push_back(smp_row(16'hFFFF));
        plan.push_back(smp_row(16'd1));

        foreach (plan[k]) begin
            if (plan[k].is_reg) write_reg(plan[k].idx, plan[k].data);
            else offer_sample(plan[k].data, plan[k].fixed, plan[k].level);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 76; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            case (ph)
                0, 1, 2: begin
                    b_sel = -32768;
                    t_sel = 32767;
                    m_sel = (ph == 0) ? int'(MID_ONE) : (ph == 1) ? 0 : 65535;
                end
                3: begin
                    b_sel = int'($urandom_range(65535)) - 32768;
                    t_sel = b_sel;
                    m_sel = pick_mid();
                end
                5: begin
                    b_sel = int'($urandom_range(32767));
                    t_sel = b_sel - 1 - int'($urandom_range(2000));
                    m_sel = pick_mid();
                end
                default: begin
                    b_sel = int'($urandom_range(65535)) - 32768;
                    span  = $urandom_range(1) ? int'($urandom_range(1, 64))
                                              : int'($urandom_range(1, 65535));
                    t_sel = b_sel + span;
                    if (t_sel > 32767) t_sel = 32767;
                    if (t_sel == b_sel) b_sel = b_sel - 1;
                    m_sel = pick_mid();
                end
            endcase
            write_reg(CFG_BLACK, b_sel[SMP_BITS-1:0]);
            write_reg(CFG_WHITE, t_sel[SMP_BITS-1:0]);
            write_reg(CFG_MID, m_sel[SMP_BITS-1:0]);
            if (ph % 3 == 0) write_reg(CFG_SPARE, SMP_BITS'($urandom));

            // Most samples land in or just around the window.
            lo = ((b_sel < t_sel) ? b_sel : t_sel) - 4;
            hi = ((b_sel < t_sel) ? t_sel : b_sel) + 4;
            if (lo < -32768) lo = -32768;
            if (hi > 32767) hi = 32767;

            if (ph == 4) hold_requests++;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 6 && k == ITEMS_PER_PHASE / 2) wait_drained();
                if ($urandom_range(9) < 7) smp = lo + int'($urandom_range(hi - lo));
                else smp = int'($urandom_range(65535)) - 32768;
                offer_sample(smp[SMP_BITS-1:0], 1'b0, '0);
            end
        end

        stall_pct = 0;
        wait_drained();
        repeat (PIPE_DEPTH + 6) @(posedge i_clk);

        $display("Covered %0d samples and %0d register writes over %0d random window settings.",
                 n_samples, n_writes, N_PHASES);
        $display("Windows: full span, collapsed, reversed, narrow; mid ratio 0, 1.0, max, random.");
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule : testbench
